>>> hdl/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit.
// No dependencies; used by rau_ctrl, rau_dp and rational_arith_unit_top.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int OpW   = 16;
	localparam int ProdW = 2 * OpW;
	localparam int SumW  = ProdW + 1;
	localparam int MagW  = ProdW + 1;
	localparam int NumW  = 33;
	localparam int DenW  = 31;
	localparam int CntW  = $clog2(MagW + 1);

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_RED = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture operands
		logic mul;      // form numerator and denominator products
		logic gcd_step; // one binary gcd step
		logic div_init; // start a restoring division
		logic div_step; // one quotient bit
		logic div_sel;  // 0 numerator, 1 denominator
		logic fin;      // build result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic skip;     // error or zero numerator: no gcd/divide needed
	} sts_t;
endpackage

>>> hdl/rau_ctrl.sv
// rau_ctrl: sequencer for the rational arithmetic unit.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_GCD;
			ST_GCD: begin
				if (sts.skip) state_nx = ST_DONE;
				else if (sts.gcd_done) state_nx = ST_DIVN;
			end
			ST_DIVN: if (sts.div_done) state_nx = ST_DIVD;
			ST_DIVD: if (sts.div_done) state_nx = ST_DONE;
			ST_DONE: if (!out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_GCD: begin
				cmd.gcd_step = !sts.gcd_done && !sts.skip;
				cmd.div_init = sts.gcd_done || sts.skip;
				cmd.fin = sts.skip;
			end
			ST_DIVN: begin
				cmd.div_step = !sts.div_done;
				cmd.div_init = sts.div_done;
				cmd.div_sel = sts.div_done;
			end
			ST_DIVD: begin
				cmd.div_sel = 1'b1;
				cmd.div_step = !sts.div_done;
				cmd.fin = sts.div_done;
			end
			ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_DONE) else $error("valid outside done");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall) else $error("accepted while busy");
endmodule

>>> hdl/rau_dp.sv
// rau_dp: products, binary gcd and restoring dividers for the rational unit.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_dp
	import rau_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  logic [2:0]             action,
	input  logic signed [OpW-1:0]  num_a,
	input  logic signed [OpW-1:0]  den_a,
	input  logic signed [OpW-1:0]  num_b,
	input  logic signed [OpW-1:0]  den_b,
	output sts_t                   sts,
	output logic signed [NumW-1:0] res_num,
	output logic [DenW-1:0]        res_den,
	output logic                   status
);
	logic [2:0] act_q;
	logic signed [OpW-1:0] a_q, b_q, c_q, d_q;
	logic err_q, neg_q;
	logic [MagW-1:0] un_q, uq_q;
	logic [MagW-1:0] gx_q, gy_q;
	logic [CntW-1:0] gsh_q;
	logic [MagW-1:0] rem_q, quo_q, dvs_q, nq_q;
	logic [CntW-1:0] dcnt_q;
	logic signed [ProdW-1:0] p1, p2, p3;
	logic signed [SumW-1:0] n_c, q_c;
	logic err_c;
	logic [MagW-1:0] gdif, rsub_in;
	logic [MagW:0] rtry;
	logic signed [NumW-1:0] rn_c;

	// capture operands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= (action > 3'(ACT_RED)) ? 3'(ACT_RED) : action;
			a_q <= num_a;
			b_q <= den_a;
			c_q <= num_b;
			d_q <= den_b;
		end
	end

	// cross products; multiplier operands selected by action
	always_comb begin
		p1 = '0; p2 = '0; p3 = '0;
		n_c = '0; q_c = '0;
		case (act_q) inside
			3'(ACT_ADD), 3'(ACT_SUB): begin
				p1 = ProdW'(a_q) * ProdW'(d_q);
				p2 = ProdW'(c_q) * ProdW'(b_q);
				p3 = ProdW'(b_q) * ProdW'(d_q);
				n_c = (act_q == 3'(ACT_ADD)) ? SumW'(p1) + SumW'(p2) : SumW'(p1) - SumW'(p2);
				q_c = SumW'(p3);
			end
			3'(ACT_MUL): begin
				p1 = ProdW'(a_q) * ProdW'(c_q);
				p3 = ProdW'(b_q) * ProdW'(d_q);
				n_c = SumW'(p1); q_c = SumW'(p3);
			end
			3'(ACT_DIV): begin
				p1 = ProdW'(a_q) * ProdW'(d_q);
				p3 = ProdW'(b_q) * ProdW'(c_q);
				n_c = SumW'(p1); q_c = SumW'(p3);
			end
			default: begin
				n_c = SumW'(a_q); q_c = SumW'(b_q);
			end
		endcase
		err_c = (b_q == '0) || (act_q != 3'(ACT_RED) && d_q == '0)
			|| (act_q == 3'(ACT_DIV) && c_q == '0) || (q_c == '0) || (n_c == '0);
	end

	// binary gcd: strip common twos, then subtract
	assign gdif = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			err_q <= (b_q == '0) || (act_q != 3'(ACT_RED) && d_q == '0)
				|| (act_q == 3'(ACT_DIV) && c_q == '0) || (q_c == '0);
			neg_q <= n_c[SumW-1] ^ q_c[SumW-1];
			un_q <= n_c[SumW-1] ? MagW'(-n_c) : MagW'(n_c);
			uq_q <= q_c[SumW-1] ? MagW'(-q_c) : MagW'(q_c);
			gx_q <= n_c[SumW-1] ? MagW'(-n_c) : MagW'(n_c);
			gy_q <= q_c[SumW-1] ? MagW'(-q_c) : MagW'(q_c);
			gsh_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gsh_q <= gsh_q + 1'b1;
			end else if (!gx_q[0]) gx_q <= gx_q >> 1;
			else if (!gy_q[0]) gy_q <= gy_q >> 1;
			else if (gx_q > gy_q) gx_q <= gdif;
			else gy_q <= gdif;
		end
	end
	logic skip_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skip_q <= 1'b0;
		else if (cmd.mul) skip_q <= err_c;
	end
	assign sts.skip = skip_q;
	assign sts.gcd_done = (gx_q == gy_q) || gx_q == '0 || gy_q == '0;

	// restoring divider, one bit per cycle, divisor = gcd
	assign rsub_in = {rem_q[MagW-2:0], quo_q[MagW-1]};
	assign rtry = {1'b0, rsub_in} - {1'b0, dvs_q};
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= cmd.div_sel ? uq_q : un_q;
			dvs_q <= (gx_q == '0 ? gy_q : gx_q) << gsh_q;
			dcnt_q <= '0;
			if (cmd.div_sel) nq_q <= quo_q;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (!rtry[MagW]) begin
				rem_q <= rtry[MagW-1:0];
				quo_q <= {quo_q[MagW-2:0], 1'b1};
			end else begin
				rem_q <= rsub_in;
				quo_q <= {quo_q[MagW-2:0], 1'b0};
			end
		end
	end
	assign sts.div_done = dcnt_q == CntW'(MagW);

	// result register
	assign rn_c = neg_q ? -NumW'(nq_q) : NumW'(nq_q);
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (skip_q) begin
				res_num <= '0;
				res_den <= DenW'(1);
				status <= err_q;
			end else begin
				res_num <= rn_c;
				res_den <= quo_q[DenW-1:0];
				status <= 1'b0;
			end
		end
	end

	a_gcd_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init && !skip_q && !cmd.div_sel |-> (gx_q != '0 || gy_q != '0))
		else $error("zero divisor");
	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !cmd.fin) else $error("double finish");
	a_skip_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && !skip_q |-> quo_q != '0) else $error("zero denominator");
endmodule

>>> hdl/rational_arith_unit_top.sv
// channel | signals                                   | direction
// input   | in_valid, in_stall, action, num_a..den_b  | request in
// output  | out_valid, out_stall, res_num, res_den, status | request out
// One request at a time: it is accepted and multiplied, binary-gcd steps run,
// then the numerator and the denominator are each divided by the gcd and the
// result is offered; the gcd loop and the dividers take most of the time.
// Errors and zero numerators skip the gcd and dividers.
// Reset is asynchronous and clears the sequencer and the skip flag. A stalled result holds.
// Depends on rau_pkg, rau_ctrl, rau_dp.
`timescale 1ns / 1ps
module rational_arith_unit_top
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] action,
	input  logic signed [OpW-1:0] num_a,
	input  logic signed [OpW-1:0] den_a,
	input  logic signed [OpW-1:0] num_b,
	input  logic signed [OpW-1:0] den_b,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [NumW-1:0] res_num,
	output logic [DenW-1:0] res_den,
	output logic status
);
	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd);
	rau_dp u_dp (.clk, .arst_n, .cmd, .action, .num_a, .den_a, .num_b, .den_b,
		.sts, .res_num, .res_den, .status);
endmodule

>>> tb/sv/rational_arith_unit_top_tb.sv
// Testbench for rational_arith_unit_top: directed and random fraction requests,
// results predicted in a scoreboard class and checked in order.
// Depends on rau_pkg and the rational_arith_unit_top RTL.
`timescale 1ns / 1ps
module rational_arith_unit_top_tb;
	import rau_pkg::*;

	typedef struct {
		logic signed [NumW-1:0] num;
		logic [DenW-1:0] den;
		logic st;
	} frac_res_t;

	// Scoreboard: predicts reduced fractions and compares results in order
	class frac_scoreboard;
		frac_res_t pending[$];
		int errors;

		function longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
			longint unsigned t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function void note_request(logic [2:0] act, logic signed [OpW-1:0] a,
				logic signed [OpW-1:0] b, logic signed [OpW-1:0] c,
				logic signed [OpW-1:0] d);
			longint n, q, an, bn, cn, dn;
			longint unsigned un, uq, g;
			logic [2:0] op;
			bit err, neg;
			frac_res_t r;
			an = a; bn = b; cn = c; dn = d;
			op = (act > ACT_RED) ? ACT_RED : act;
			err = (bn == 0) || (op != ACT_RED && dn == 0) || (op == ACT_DIV && cn == 0);
			case (op)
				ACT_ADD: begin n = an * dn + cn * bn; q = bn * dn; end
				ACT_SUB: begin n = an * dn - cn * bn; q = bn * dn; end
				ACT_MUL: begin n = an * cn; q = bn * dn; end
				ACT_DIV: begin n = an * dn; q = bn * cn; end
				default: begin n = an; q = bn; end
			endcase
			if (err || q == 0) begin
				r.num = 0; r.den = 1; r.st = 1'b1;
			end else begin
				neg = (n < 0) != (q < 0);
				un = (n < 0) ? -n : n;
				uq = (q < 0) ? -q : q;
				if (un == 0) begin
					uq = 1; neg = 0;
				end else begin
					g = euclid_gcd(un, uq);
					un = un / g;
					uq = uq / g;
				end
				if (neg) un = -un;
				r.num = un[NumW-1:0]; r.den = uq[DenW-1:0]; r.st = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [NumW-1:0] num, logic [DenW-1:0] den,
				logic st);
			frac_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d st %0b", $time, num, den, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (num !== e.num) begin
				$display("%0t: res_num exp %0d got %0d", $time, e.num, num);
				errors++;
			end
			if (den !== e.den) begin
				$display("%0t: res_den exp %0d got %0d", $time, e.den, den);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status exp %0b got %0b", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall, status;
	logic [2:0] action;
	logic signed [OpW-1:0] num_a, den_a, num_b, den_b;
	logic signed [NumW-1:0] res_num;
	logic [DenW-1:0] res_den;
	frac_scoreboard sb;

	rational_arith_unit_top dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit: a timeout well above the time the ~1800 requests need
	initial begin
		#40ms;
		$display("rational_arith_unit_top_tb: FAIL");
		$finish;
	end

	// Pick an operand: extremes, small values or fully random
	function automatic logic signed [OpW-1:0] pick_op();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3, 4, 5: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one request and wait for its acceptance
	task automatic send_request(logic [2:0] act, logic signed [OpW-1:0] a,
			logic signed [OpW-1:0] b, logic signed [OpW-1:0] c,
			logic signed [OpW-1:0] d);
		int gap;
		gap = $urandom_range(0, 6);
		in_valid <= 1'b1;
		action <= act; num_a <= a; den_a <= b; num_b <= c; den_b <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(act, a, b, c, d);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random stall, check on every accepted result
	initial begin
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) hold = 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(res_num, res_den, status);
		end
	end

	initial begin
		logic [2:0] act;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0; num_a = '0; den_a = '0; num_b = '0; den_b = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every action, extremes, zero denominators, zero results
		for (int i = 0; i < 5; i++) begin
			send_request(i[2:0], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
			send_request(i[2:0], 16'sh7fff, -16'sd1, 16'sh8000, 16'sh8000);
		end
		send_request(ACT_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2);
		send_request(ACT_SUB, 16'sd3, 16'sd4, 16'sd1, 16'sd0);
		send_request(ACT_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
		send_request(ACT_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
		send_request(ACT_MUL, 16'sd0, -16'sd7, 16'sd5, 16'sd9);
		send_request(ACT_SUB, 16'sd1, -16'sd2, 16'sd1, -16'sd3);
		send_request(ACT_RED, 16'sd6, -16'sd4, 16'sd0, 16'sd0);
		send_request(ACT_RED, 16'sd5, 16'sd0, 16'sd1, 16'sd1);
		send_request(3'd5, -16'sd12, 16'sd18, 16'sd0, 16'sd0);
		send_request(3'd6, 16'sh7fff, 16'sh7ffe, 16'sd1, 16'sd1);
		send_request(3'd7, -16'sd1, -16'sd1, 16'shffff, 16'sh0000);
		send_request(ACT_DIV, 16'sh8000, 16'sh8000, -16'sd1, 16'sh8000);

		// Random: mostly nonzero denominators, some error cases
		for (int i = 0; i < 1800; i++) begin
			act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_request(act, pick_op(), pick_op(), pick_op(), pick_op());
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("rational_arith_unit_top_tb: PASS");
		else
			$display("rational_arith_unit_top_tb: FAIL");
		$finish;
	end
endmodule

>>> files.f
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arith_unit_top.sv
tb/sv/rational_arith_unit_top_tb.sv
